@@ sv/roro_pkg.sv @@
// ----------------------------------------------------------------------------
// roro_pkg
// shared constants, types and helpers for the record ring with offset lookup
// ----------------------------------------------------------------------------
package roro_pkg;

	localparam int SLOTS   = 16;
	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HDL_W   = 32;
	localparam int LEN_W   = 16;
	localparam int POS_W   = 20;
	localparam int SLOT_W  = 4;
	localparam int REC_W   = HDL_W + LEN_W;
	localparam int SUM_W   = LEN_W + IDX_W;
	localparam int CMP_W   = ((SUM_W > POS_W) ? SUM_W : POS_W) + 1;
	localparam int STEP_W  = IDX_W;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_FIND = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_FIND
	} state_t;

	function automatic idx_t next_slot(input idx_t p);
		idx_t r;
		if (p == idx_t'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = p + idx_t'(1);
		end
		return r;
	endfunction

endpackage

@@ sv/roro_ram.sv @@
// ----------------------------------------------------------------------------
// roro_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module roro_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ sv/ring_of_records_offset_lookup_top.sv @@
// ----------------------------------------------------------------------------
// ring_of_records_offset_lookup_top
// ring of records (handle, byte length) with oldest-first byte offset lookup
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. An add passes through
// its ADD state and then shows its result on done; a find shows it once its
// walk ends, after k records (1..SLOTS) walked, one per cycle through
// the single read port of the record memory. busy falls in the cycle done is
// high, so the next start may come then. The result holds for that one cycle
// only: there is no way to stall it, so it must be taken when done is high.
// ----------------------------------------------------------------------------
module ring_of_records_offset_lookup_top
	import roro_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             operation,
	input  logic [HDL_W-1:0] record_handle,
	input  logic [LEN_W-1:0] record_length,
	input  logic [POS_W-1:0] byte_position,
	output logic             done,
	output logic             found,
	output logic [SLOT_W-1:0] slot_number,
	output logic [HDL_W-1:0] found_handle,
	output logic [LEN_W-1:0] offset_within,
	output logic             evicted,
	output logic [HDL_W-1:0] evicted_handle
);

	state_t state_q, state_d;

	idx_t             wp_q, rp_q, rd_idx_q;
	logic             full_q;
	logic [SLOTS-1:0] valid_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0] base_q;
	logic             done_q;

	logic [HDL_W-1:0] hdl_q;
	logic [LEN_W-1:0] len_q;
	logic [POS_W-1:0] pos_q;

	logic             found_q, evicted_q;
	logic [SLOT_W-1:0] slot_q;
	logic [HDL_W-1:0] fhdl_q, ehdl_q;
	logic [LEN_W-1:0] off_q;

	logic             accept;
	logic             ram_we;
	idx_t             ram_rd_addr;
	logic [REC_W-1:0] ram_rd_data;
	logic [HDL_W-1:0] rd_hdl;
	logic [LEN_W-1:0] rd_len;
	logic [CMP_W-1:0] diff;
	logic             hit;
	logic             last;
	idx_t             wp_next, rp_next;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	roro_ram #(
		.WIDTH (REC_W),
		.DEPTH (SLOTS)
	) u_rec_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (wp_q),
		.wr_data ({hdl_q, len_q}),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// length of a slot never written reads as zero
	assign rd_hdl = ram_rd_data[REC_W-1:LEN_W];
	assign rd_len = valid_q[rd_idx_q] ? ram_rd_data[LEN_W-1:0] : '0;
	assign diff   = CMP_W'(pos_q) - CMP_W'(base_q);
	assign hit    = !diff[CMP_W-1] && (diff[CMP_W-2:0] < (CMP_W-1)'(rd_len));
	assign last   = (step_q == STEP_W'(SLOTS - 1));

	assign wp_next = next_slot(wp_q);
	assign rp_next = full_q ? next_slot(rp_q) : rp_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (op_t'(operation) == OP_ADD) ? ST_ADD : ST_FIND;
				end
			end
			ST_ADD: begin
				state_d = ST_IDLE;
			end
			ST_FIND: begin
				if (hit || last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ram_we      = 1'b0;
		ram_rd_addr = rp_q;
		unique case (state_q)
			ST_IDLE: begin
				ram_rd_addr = rp_q;
			end
			ST_ADD: begin
				ram_we = 1'b1;
			end
			ST_FIND: begin
				ram_rd_addr = next_slot(rd_idx_q);
			end
			default: begin
				ram_rd_addr = rp_q;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			full_q  <= 1'b0;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == ST_ADD) begin
				wp_q             <= wp_next;
				rp_q             <= rp_next;
				full_q           <= (wp_next == rp_next);
				valid_q[wp_q]    <= 1'b1;
				done_q           <= 1'b1;
			end
			if ((state_q == ST_FIND) && (hit || last)) begin
				done_q <= 1'b1;
			end
		end
	end

	// beat capture, walk and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			hdl_q    <= record_handle;
			len_q    <= record_length;
			pos_q    <= byte_position;
			rd_idx_q <= rp_q;
			step_q   <= '0;
			base_q   <= '0;
		end
		if (state_q == ST_ADD) begin
			found_q   <= 1'b0;
			slot_q    <= '0;
			fhdl_q    <= '0;
			off_q     <= '0;
			evicted_q <= full_q;
			ehdl_q    <= full_q ? rd_hdl : '0;
		end
		if (state_q == ST_FIND) begin
			rd_idx_q  <= next_slot(rd_idx_q);
			step_q    <= step_q + STEP_W'(1);
			base_q    <= base_q + SUM_W'(rd_len);
			evicted_q <= 1'b0;
			ehdl_q    <= '0;
			found_q   <= hit;
			slot_q    <= hit ? SLOT_W'(rd_idx_q) : '0;
			fhdl_q    <= hit ? rd_hdl : '0;
			off_q     <= hit ? LEN_W'(diff) : '0;
		end
	end

	assign done           = done_q;
	assign found          = found_q;
	assign slot_number    = slot_q;
	assign found_handle   = fhdl_q;
	assign offset_within  = off_q;
	assign evicted        = evicted_q;
	assign evicted_handle = ehdl_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(found && evicted))
		else $error("result beat both found and evicted");

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (wp_q == rp_q))
		else $error("ring full with pointers apart");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("no busy after accepted beat");

endmodule
